// ----- rtl/core/uer_pkg.sv -----
// shared types, register indexes and constants for the echo ranger core
// no dependencies; every rtl/core module refers to this package by scoped names
package uer_pkg;

  localparam int CNT_W   = 20;
  localparam int DIST_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = 1;

  localparam logic [1:0] CMD_IDLE    = 2'd0;
  localparam logic [1:0] CMD_MEASURE = 2'd1;
  localparam logic [1:0] CMD_LED_ON  = 2'd2;
  localparam logic [1:0] CMD_LED_OFF = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NOOBJ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WAIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIM  = 3'd5;

  localparam logic [DIST_W-1:0] FAIL_CM  = 11'd1129;
  localparam logic [DIST_W-1:0] OK_CM_MAX = 11'd564;

  // x / 58 for x below 2^15 as (x * 36158) >> 21
  localparam int DIV58_MUL   = 36158;
  localparam int DIV58_SHIFT = 21;
  // x / 10 for x below 1000 as (x * 205) >> 11
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  // x / 10 for x below 100 as (x * 103) >> 10
  localparam int DIV10S_MUL   = 103;
  localparam int DIV10S_SHIFT = 10;

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic measure;
    logic echo;
    logic led;
  } q_item_t;

  typedef struct packed {
    logic              trig;
    logic              led;
    logic              busy;
    logic              done;
    logic [1:0]        status;
    logic [DIST_W-1:0] cm;
  } res_t;

  typedef struct packed {
    res_t       r;
    logic [5:0] thou;
    logic [5:0] hund;
    logic [5:0] tens;
    logic [5:0] ones;
  } out_t;

endpackage

// ----- rtl/core/uer_front.sv -----
// front end: takes input beats, decodes the command and tracks the led
// depends on uer_pkg; feeds uer_fifo
module uer_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic              echo_level,
  input  logic              q_full,
  output logic              push,
  output uer_pkg::q_item_t  item
);

  logic led;
  logic led_next;
  logic measure;

  always_comb begin
    led_next = led;
    measure  = 1'b0;
    unique case (command)
      uer_pkg::CMD_IDLE:    ;
      uer_pkg::CMD_MEASURE: measure = 1'b1;
      uer_pkg::CMD_LED_ON:  led_next = 1'b1;
      uer_pkg::CMD_LED_OFF: led_next = 1'b0;
    endcase
  end

  assign in_ready     = !q_full;
  assign push         = in_valid && in_ready;
  assign item.measure = measure;
  assign item.echo    = echo_level;
  assign item.led     = led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      led <= 1'b0;
    end else if (push) begin
      led <= led_next;
    end
  end

endmodule

// ----- rtl/core/uer_fifo.sv -----
// two-entry queue between the front end and the sequencer
// depends on uer_pkg
module uer_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  uer_pkg::q_item_t  item_in,
  output logic              full,
  output logic              valid,
  input  logic              pop,
  output uer_pkg::q_item_t  item_out
);

  localparam int CNT_BITS = $clog2(uer_pkg::Q_DEPTH + 1);

  uer_pkg::q_item_t mem [uer_pkg::Q_DEPTH];
  logic [uer_pkg::QPTR_W-1:0] wr_ptr;
  logic [uer_pkg::QPTR_W-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full     = count == CNT_BITS'(uer_pkg::Q_DEPTH);
  assign valid    = count != '0;
  assign item_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

// ----- rtl/core/uer_seq.sv -----
// measurement sequencer with timing registers, then the width to centimeter stage
// depends on uer_pkg; pulls ticks from uer_fifo, feeds uer_digits
module uer_seq (
  input  logic              clk,
  input  logic              rst,
  input  uer_pkg::cfg_wr_t  cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  uer_pkg::q_item_t  q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output uer_pkg::res_t     res
);

  localparam int CW = uer_pkg::CNT_W;
  localparam int HALF_W = 15;
  localparam int PROD_W = HALF_W + 16;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SETTLE = 3'd1;
  localparam logic [2:0] PH_TLOW   = 3'd2;
  localparam logic [2:0] PH_THIGH  = 3'd3;
  localparam logic [2:0] PH_POST   = 3'd4;
  localparam logic [2:0] PH_RISE   = 3'd5;
  localparam logic [2:0] PH_HIGH   = 3'd6;

  function automatic logic [CW-1:0] min1(input logic [CW-1:0] v);
    min1 = (v == '0) ? CW'(1) : v;
  endfunction

  logic [19:0] settle_ticks;
  logic [7:0]  trig_low_ticks;
  logic [7:0]  trig_high_ticks;
  logic [7:0]  post_ticks;
  logic [19:0] edge_wait_limit;
  logic [15:0] echo_limit;

  logic [2:0]    phase;
  logic [2:0]    phase_next;
  logic [CW-1:0] tick_count;
  logic [CW-1:0] tick_count_next;
  logic [CW-1:0] tc_inc;
  logic [CW-1:0] tc_sat;
  logic [CW-1:0] ewl_eff;
  logic          trig;
  logic          fin;
  logic [1:0]    fin_st;

  logic              a_v;
  logic              a_trig;
  logic              a_led;
  logic              a_busy;
  logic              a_fin;
  logic [1:0]        a_status;
  logic [HALF_W-1:0] a_half;

  logic              b_v;
  logic [uer_pkg::DIST_W-1:0] last_distance;
  logic [1:0]                 last_status;
  logic [uer_pkg::DIST_W-1:0] new_dist;
  logic [1:0]                 new_status;
  logic [PROD_W-1:0]          prod;

  logic a_ready;
  logic b_ok;
  logic advance;

  assign tc_inc  = tick_count + 1'b1;
  assign tc_sat  = (tick_count == '1) ? tick_count : tc_inc;
  assign ewl_eff = min1(CW'(edge_wait_limit));

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    trig            = 1'b0;
    fin             = 1'b0;
    fin_st          = uer_pkg::ST_OK;
    unique case (phase)
      PH_IDLE: begin
        if (q_item.measure) begin
          phase_next      = PH_SETTLE;
          tick_count_next = '0;
        end
      end
      PH_SETTLE: begin
        if (tc_inc >= min1(CW'(settle_ticks))) begin
          phase_next      = PH_TLOW;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_TLOW: begin
        if (tc_inc >= min1(CW'(trig_low_ticks))) begin
          phase_next      = PH_THIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_THIGH: begin
        trig = 1'b1;
        if (tc_inc >= min1(CW'(trig_high_ticks))) begin
          phase_next      = PH_POST;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_POST: begin
        if (tc_inc >= min1(CW'(post_ticks))) begin
          phase_next      = PH_RISE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_RISE: begin
        if (q_item.echo) begin
          phase_next      = PH_HIGH;
          tick_count_next = CW'(1);
        end else if (tc_inc >= ewl_eff) begin
          fin    = 1'b1;
          fin_st = uer_pkg::ST_TIMEOUT;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_HIGH: begin
        if (q_item.echo) begin
          if (tc_sat > CW'(echo_limit)) begin
            fin    = 1'b1;
            fin_st = uer_pkg::ST_NOOBJ;
          end else if (tc_sat >= ewl_eff) begin
            fin    = 1'b1;
            fin_st = uer_pkg::ST_TIMEOUT;
          end else begin
            tick_count_next = tc_sat;
          end
        end else begin
          fin    = 1'b1;
          fin_st = uer_pkg::ST_OK;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    if (fin) begin
      phase_next      = PH_IDLE;
      tick_count_next = '0;
    end
  end

  assign b_ok    = !b_v || res_ready;
  assign a_ready = !a_v || b_ok;
  assign advance = q_valid && a_ready;
  assign q_pop   = advance;

  assign prod = PROD_W'(a_half) * PROD_W'(uer_pkg::DIV58_MUL);

  always_comb begin
    new_dist   = last_distance;
    new_status = last_status;
    if (a_fin) begin
      new_status = a_status;
      if (a_status == uer_pkg::ST_OK) begin
        new_dist = uer_pkg::DIST_W'(prod[uer_pkg::DIV58_SHIFT +: 10]);
      end else begin
        new_dist = uer_pkg::FAIL_CM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks    <= 20'd100000;
      trig_low_ticks  <= 8'd20;
      trig_high_ticks <= 8'd30;
      post_ticks      <= 8'd40;
      edge_wait_limit <= 20'd600000;
      echo_limit      <= 16'd60000;
      phase           <= PH_IDLE;
      tick_count      <= '0;
      a_v             <= 1'b0;
      b_v             <= 1'b0;
      last_distance   <= '0;
      last_status     <= uer_pkg::ST_OK;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          uer_pkg::REG_SETTLE:    settle_ticks    <= cfg.data;
          uer_pkg::REG_TRIG_LOW:  trig_low_ticks  <= cfg.data[7:0];
          uer_pkg::REG_TRIG_HIGH: trig_high_ticks <= cfg.data[7:0];
          uer_pkg::REG_POST:      post_ticks      <= cfg.data[7:0];
          uer_pkg::REG_EDGE_WAIT: edge_wait_limit <= cfg.data;
          uer_pkg::REG_ECHO_LIM:  echo_limit      <= cfg.data[15:0];
          default: ;
        endcase
      end
      if (advance) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
      end
      if (a_ready) begin
        a_v <= q_valid;
      end
      if (b_ok) begin
        b_v <= a_v;
      end
      if (a_v && b_ok) begin
        last_distance <= new_dist;
        last_status   <= new_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_trig   <= trig;
      a_led    <= q_item.led;
      a_busy   <= phase_next != PH_IDLE;
      a_fin    <= fin;
      a_status <= fin_st;
      a_half   <= tick_count[HALF_W:1];
    end
    if (a_v && b_ok) begin
      res.trig   <= a_trig;
      res.led    <= a_led;
      res.busy   <= a_busy;
      res.done   <= a_fin;
      res.status <= new_status;
      res.cm     <= new_dist;
    end
  end

  assign res_valid = b_v;

endmodule

// ----- rtl/core/uer_digits.sv -----
// three-stage split of the distance into ascii decimal digits, last stage is the output register
// depends on uer_pkg; fed by uer_seq
module uer_digits (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  uer_pkg::res_t  in_res,
  output logic           out_valid,
  input  logic           out_ready,
  output uer_pkg::out_t  out
);

  localparam int P1_W = 18;
  localparam int P2_W = 14;

  logic          c_v;
  uer_pkg::res_t c_res;
  logic [1:0]    c_th;
  logic [9:0]    c_r1;

  logic          d_v;
  uer_pkg::res_t d_res;
  logic [1:0]    d_th;
  logic [6:0]    d_t;
  logic [3:0]    d_ones;

  logic          e_v;

  logic [1:0]      th;
  logic [9:0]      r1;
  logic [P1_W-1:0] p1;
  logic [6:0]      t;
  logic [3:0]      ones;
  logic [P2_W-1:0] p2;
  logic [3:0]      hund;
  logic [3:0]      tens;

  logic e_ok;
  logic d_ok;
  logic c_ok;

  always_comb begin
    if (in_res.cm >= 11'd2000) begin
      th = 2'd2;
      r1 = 10'(in_res.cm - 11'd2000);
    end else if (in_res.cm >= 11'd1000) begin
      th = 2'd1;
      r1 = 10'(in_res.cm - 11'd1000);
    end else begin
      th = 2'd0;
      r1 = in_res.cm[9:0];
    end
  end

  assign p1   = P1_W'(c_r1) * P1_W'(uer_pkg::DIV10_MUL);
  assign t    = p1[uer_pkg::DIV10_SHIFT +: 7];
  assign ones = 4'(c_r1 - 10'(t) * 10'd10);

  assign p2   = P2_W'(d_t) * P2_W'(uer_pkg::DIV10S_MUL);
  assign hund = p2[uer_pkg::DIV10S_SHIFT +: 4];
  assign tens = 4'(d_t - 7'(hund) * 7'd10);

  assign e_ok     = !e_v || out_ready;
  assign d_ok     = !d_v || e_ok;
  assign c_ok     = !c_v || d_ok;
  assign in_ready = c_ok;
  assign out_valid = e_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      if (c_ok) begin
        c_v <= in_valid;
      end
      if (d_ok) begin
        d_v <= c_v;
      end
      if (e_ok) begin
        e_v <= d_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && c_ok) begin
      c_res <= in_res;
      c_th  <= th;
      c_r1  <= r1;
    end
    if (c_v && d_ok) begin
      d_res  <= c_res;
      d_th   <= c_th;
      d_t    <= t;
      d_ones <= ones;
    end
    if (d_v && e_ok) begin
      out.r    <= d_res;
      out.thou <= uer_pkg::ASCII_ZERO + 6'(d_th);
      out.hund <= uer_pkg::ASCII_ZERO + 6'(hund);
      out.tens <= uer_pkg::ASCII_ZERO + 6'(tens);
      out.ones <= uer_pkg::ASCII_ZERO + 6'(d_ones);
    end
  end

endmodule

// ----- rtl/core/ultrasonic_echo_ranger_core.sv -----
// Ultrasonic echo ranger core. Each input beat is one 0.5 us tick with a command and the
// sampled echo level, and each tick gives exactly one result beat. The block takes one tick
// per clock cycle sustained while the result side keeps taking results; a tick's result passes
// through the two-entry input queue, the phase sequencer register, the divide-by-58 multiplier
// stage and three digit stages, the last of them the output register, and the rate of one tick
// a cycle is set by the sequencer, which advances one tick a cycle when not stalled.
// Timing registers are written through the cfg port (index 0 settle_ticks to 5 echo_limit),
// are taken at any cycle and are meant to be changed only while the block is idle.
// depends on uer_pkg, uer_front, uer_fifo, uer_seq, uer_digits
module ultrasonic_echo_ranger_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic        echo_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        trigger_out,
  output logic        led_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [1:0]  status,
  output logic [10:0] distance_cm,
  output logic [5:0]  digit_thousands,
  output logic [5:0]  digit_hundreds,
  output logic [5:0]  digit_tens,
  output logic [5:0]  digit_ones,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  uer_pkg::cfg_wr_t cfg;
  uer_pkg::q_item_t f_item;
  uer_pkg::q_item_t q_item;
  uer_pkg::res_t    res;
  uer_pkg::out_t    out;

  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic res_valid;
  logic res_ready;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  uer_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .echo_level (echo_level),
    .q_full     (q_full),
    .push       (push),
    .item       (f_item)
  );

  uer_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (f_item),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .item_out (q_item)
  );

  uer_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  uer_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out       (out)
  );

  assign trigger_out     = out.r.trig;
  assign led_out         = out.r.led;
  assign busy_res        = out.r.busy;
  assign done_res        = out.r.done;
  assign status          = out.r.status;
  assign distance_cm     = out.r.cm;
  assign digit_thousands = out.thou;
  assign digit_hundreds  = out.hund;
  assign digit_tens      = out.tens;
  assign digit_ones      = out.ones;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done result still marked busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_out |-> busy_res && !done_res)
    else $error("trigger driven outside a measurement");

  a_fail_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != uer_pkg::ST_OK |-> distance_cm == uer_pkg::FAIL_CM)
    else $error("failed measurement without fail distance");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == uer_pkg::ST_OK |-> distance_cm <= uer_pkg::OK_CM_MAX)
    else $error("distance out of range");

endmodule

// ----- tb/testbench.sv -----
// testbench for ultrasonic_echo_ranger_core: tick stimulus with a tick-by-tick result predictor,
// random stalls on both handshakes and timing registers reloaded between test phases
// depends on uer_pkg and the core rtl under rtl/core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_TICKS = 150;
  localparam int CM_DIVISOR = 58;
  localparam logic [uer_pkg::CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SETTLE, SEQ_TLOW, SEQ_THIGH, SEQ_POST, SEQ_RISE, SEQ_HIGH
  } seq_phase_t;

  typedef struct {
    logic                       trig;
    logic                       led;
    logic                       busy;
    logic                       done;
    logic [1:0]                 status;
    logic [uer_pkg::DIST_W-1:0] cm;
    logic [5:0]                 thou;
    logic [5:0]                 hund;
    logic [5:0]                 tens;
    logic [5:0]                 ones;
  } ranger_beat_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     command = uer_pkg::CMD_IDLE;
  logic                           echo_level = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           trigger_out;
  logic                           led_out;
  logic                           busy_res;
  logic                           done_res;
  logic [1:0]                     status;
  logic [uer_pkg::DIST_W-1:0]     distance_cm;
  logic [5:0]                     digit_thousands;
  logic [5:0]                     digit_hundreds;
  logic [5:0]                     digit_tens;
  logic [5:0]                     digit_ones;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index = uer_pkg::REG_SETTLE;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // tick predictor state and its copy of the timing registers
  seq_phase_t                 ph = SEQ_IDLE;
  logic [uer_pkg::CNT_W-1:0]  ticks = '0;
  logic                       led_q = 1'b0;
  logic [uer_pkg::DIST_W-1:0] last_cm = '0;
  logic [1:0]                 last_st = uer_pkg::ST_OK;
  logic [19:0]                settle_cfg = 20'd100000;
  logic [7:0]                 tlow_cfg = 8'd20;
  logic [7:0]                 thigh_cfg = 8'd30;
  logic [7:0]                 post_cfg = 8'd40;
  logic [19:0]                edge_wait_cfg = 20'd600000;
  logic [15:0]                echo_lim_cfg = 16'd60000;

  ranger_beat_t expected_beats[$];
  int unsigned  failures = 0;
  int unsigned  sent_ticks = 0;
  int unsigned  quiet_cycles = 0;
  int           sink_hold = 0;
  bit           no_idling = 1'b0;

  ultrasonic_echo_ranger_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [uer_pkg::CNT_W-1:0] at_least_one(
      input logic [uer_pkg::CNT_W-1:0] v);
    return (v == '0) ? uer_pkg::CNT_W'(1) : v;
  endfunction

  function automatic void conclude(input logic [1:0] st,
                                   input logic [uer_pkg::DIST_W-1:0] cm);
    last_st = st;
    last_cm = cm;
    ph = SEQ_IDLE;
    ticks = '0;
  endfunction

  function automatic void step_timed(input logic [uer_pkg::CNT_W-1:0] dur,
                                     input seq_phase_t nxt);
    ticks = ticks + 1'b1;
    if (ticks >= at_least_one(dur)) begin
      ph = nxt;
      ticks = '0;
    end
  endfunction

  function automatic void predict_tick(input logic [1:0] cmd, input logic echo);
    ranger_beat_t b;
    logic trig;
    logic done;
    logic [uer_pkg::CNT_W-1:0] half;
    trig = 1'b0;
    done = 1'b0;
    if (cmd == uer_pkg::CMD_LED_ON) led_q = 1'b1;
    else if (cmd == uer_pkg::CMD_LED_OFF) led_q = 1'b0;
    case (ph)
      SEQ_IDLE: begin
        if (cmd == uer_pkg::CMD_MEASURE) begin
          ph = SEQ_SETTLE;
          ticks = '0;
        end
      end
      SEQ_SETTLE: step_timed(settle_cfg, SEQ_TLOW);
      SEQ_TLOW: step_timed(uer_pkg::CNT_W'(tlow_cfg), SEQ_THIGH);
      SEQ_THIGH: begin
        trig = 1'b1;
        step_timed(uer_pkg::CNT_W'(thigh_cfg), SEQ_POST);
      end
      SEQ_POST: step_timed(uer_pkg::CNT_W'(post_cfg), SEQ_RISE);
      SEQ_RISE: begin
        if (echo) begin
          ph = SEQ_HIGH;
          ticks = uer_pkg::CNT_W'(1);
        end else begin
          ticks = ticks + 1'b1;
          if (ticks >= at_least_one(edge_wait_cfg)) begin
            conclude(uer_pkg::ST_TIMEOUT, uer_pkg::FAIL_CM);
            done = 1'b1;
          end
        end
      end
      SEQ_HIGH: begin
        if (echo) begin
          if (ticks != CNT_MAX) ticks = ticks + 1'b1;
          if (ticks > uer_pkg::CNT_W'(echo_lim_cfg)) begin
            conclude(uer_pkg::ST_NOOBJ, uer_pkg::FAIL_CM);
            done = 1'b1;
          end else if (ticks >= at_least_one(edge_wait_cfg)) begin
            conclude(uer_pkg::ST_TIMEOUT, uer_pkg::FAIL_CM);
            done = 1'b1;
          end
        end else begin
          half = ticks >> 1;
          conclude(uer_pkg::ST_OK, uer_pkg::DIST_W'(half / CM_DIVISOR));
          done = 1'b1;
        end
      end
      default: begin
        ph = SEQ_IDLE;
        ticks = '0;
      end
    endcase
    b.trig = trig;
    b.led = led_q;
    b.busy = (ph != SEQ_IDLE);
    b.done = done;
    b.status = last_st;
    b.cm = last_cm;
    b.thou = 6'((last_cm / 1000) % 10 + uer_pkg::ASCII_ZERO);
    b.hund = 6'((last_cm % 1000) / 100 + uer_pkg::ASCII_ZERO);
    b.tens = 6'((last_cm % 100) / 10 + uer_pkg::ASCII_ZERO);
    b.ones = 6'(last_cm % 10 + uer_pkg::ASCII_ZERO);
    expected_beats.push_back(b);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    ranger_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no tick waiting for it");
        failures++;
      end else begin
        want = expected_beats.pop_front();
        check_field("trigger_out", want.trig, trigger_out);
        check_field("led_out", want.led, led_out);
        check_field("busy_res", want.busy, busy_res);
        check_field("done_res", want.done, done_res);
        check_field("status", want.status, status);
        check_field("distance_cm", want.cm, distance_cm);
        check_field("digit_thousands", want.thou, digit_thousands);
        check_field("digit_hundreds", want.hund, digit_hundreds);
        check_field("digit_tens", want.tens, digit_tens);
        check_field("digit_ones", want.ones, digit_ones);
      end
    end
  end

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (!no_idling && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [1:0] cmd, input logic echo);
    if (!no_idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    echo_level <= echo;
    predict_tick(cmd, echo);
    sent_ticks++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_cmd(input bit noisy);
    return noisy ? 2'($urandom_range(0, 3)) : uer_pkg::CMD_IDLE;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_timing(input logic [19:0] settle, input logic [7:0] tlow,
                             input logic [7:0] thigh, input logic [7:0] post,
                             input logic [19:0] edge_wait, input logic [15:0] echo_lim);
    logic [uer_pkg::CFG_IDX_W-1:0] idxs [6];
    logic [uer_pkg::CFG_DATA_W-1:0] vals [6];
    idxs = '{uer_pkg::REG_SETTLE, uer_pkg::REG_TRIG_LOW, uer_pkg::REG_TRIG_HIGH,
             uer_pkg::REG_POST, uer_pkg::REG_EDGE_WAIT, uer_pkg::REG_ECHO_LIM};
    vals = '{settle, 20'(tlow), 20'(thigh), 20'(post), edge_wait, 20'(echo_lim)};
    while (ph != SEQ_IDLE) send_tick(uer_pkg::CMD_IDLE, 1'b0);
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settle_cfg = settle;
    tlow_cfg = tlow;
    thigh_cfg = thigh;
    post_cfg = post;
    edge_wait_cfg = edge_wait;
    echo_lim_cfg = echo_lim;
  endtask

  task automatic run_measurement(input int rise_delay, input int high_width, input bit noisy);
    send_tick(uer_pkg::CMD_MEASURE, 1'($urandom_range(0, 1)));
    while (ph != SEQ_IDLE && ph != SEQ_RISE && ph != SEQ_HIGH)
      send_tick(pick_cmd(noisy), 1'($urandom_range(0, 1)));
    for (int i = 0; i < rise_delay && ph == SEQ_RISE; i++) send_tick(pick_cmd(noisy), 1'b0);
    for (int i = 0; i < high_width && ph != SEQ_IDLE; i++) send_tick(pick_cmd(noisy), 1'b1);
    while (ph != SEQ_IDLE) send_tick(pick_cmd(noisy), 1'b0);
  endtask

  // random commands and echo with no regard for the sequence
  task automatic stray_ticks();
    repeat ($urandom_range(1, 6)) send_tick(pick_cmd(1'b1), 1'($urandom_range(0, 1)));
    while (ph != SEQ_IDLE) send_tick(pick_cmd(1'b1), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_idle_and_led();
    send_tick(uer_pkg::CMD_IDLE, 1'b1);
    send_tick(uer_pkg::CMD_LED_ON, 1'b0);
    send_tick(uer_pkg::CMD_LED_ON, 1'b1);
    send_tick(uer_pkg::CMD_LED_OFF, 1'b0);
    send_tick(uer_pkg::CMD_IDLE, 1'b0);
  endtask

  task automatic test_zero_durations();
    load_timing(20'd0, 8'd0, 8'd0, 8'd0, 20'd3, 16'd20);
    run_measurement(1, 5, 1'b0);
  endtask

  task automatic test_busy_commands();
    load_timing(20'd2, 8'd1, 8'd2, 8'd1, 20'd6, 16'd10);
    send_tick(uer_pkg::CMD_MEASURE, 1'b0);
    send_tick(uer_pkg::CMD_MEASURE, 1'b1);
    send_tick(uer_pkg::CMD_LED_ON, 1'b0);
    send_tick(uer_pkg::CMD_MEASURE, 1'b0);
    send_tick(uer_pkg::CMD_LED_OFF, 1'b1);
    send_tick(uer_pkg::CMD_LED_ON, 1'b0);
    while (ph != SEQ_RISE) send_tick(uer_pkg::CMD_IDLE, 1'b0);
    // echo high on the very first watched tick
    send_tick(uer_pkg::CMD_MEASURE, 1'b1);
    send_tick(uer_pkg::CMD_LED_OFF, 1'b1);
    send_tick(uer_pkg::CMD_IDLE, 1'b0);
  endtask

  task automatic test_edge_timeout();
    load_timing(20'd1, 8'd1, 8'd1, 8'd0, 20'd4, 16'd30);
    run_measurement(10, 0, 1'b0);
    load_timing(20'd1, 8'd1, 8'd1, 8'd1, 20'd5, 16'd10);
    run_measurement(0, 20, 1'b0);
    load_timing(20'd1, 8'd1, 8'd1, 8'd1, 20'd0, 16'd10);
    run_measurement(5, 0, 1'b0);
  endtask

  task automatic test_no_obstacle();
    load_timing(20'd1, 8'd2, 8'd1, 8'd1, 20'd50, 16'd3);
    run_measurement(2, 10, 1'b0);
    load_timing(20'd0, 8'd1, 8'd1, 8'd0, 20'd50, 16'd0);
    run_measurement(0, 4, 1'b0);
  endtask

  task automatic test_extremes();
    // longest settle is written but never run through
    load_timing(20'hFFFFF, 8'd255, 8'd255, 8'd255, 20'd10, 16'd10);
    send_tick(uer_pkg::CMD_LED_ON, 1'b1);
    send_tick(uer_pkg::CMD_LED_OFF, 1'b0);
    load_timing(20'd1, 8'd1, 8'd1, 8'd1, 20'hFFFFF, 16'hFFFF);
    run_measurement(10, 100, 1'b0);
  endtask

  task automatic test_random_ranging();
    int unsigned first;
    bit long_echo;
    logic [19:0] edge_wait;
    logic [15:0] echo_lim;
    first = sent_ticks;
    while (sent_ticks - first < RANDOM_TICKS) begin
      long_echo = ($urandom_range(0, 3) == 0);
      edge_wait = long_echo ? 20'($urandom_range(150, 300)) : 20'($urandom_range(1, 120));
      echo_lim = long_echo ? 16'($urandom_range(120, 250)) : 16'($urandom_range(0, 60));
      load_timing(20'($urandom_range(0, 6)), 8'($urandom_range(0, 5)),
                  8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)), edge_wait, echo_lim);
      repeat ($urandom_range(3, 8)) begin
        if (sent_ticks - first >= RANDOM_TICKS) break;
        if ($urandom_range(0, 3) == 0) stray_ticks();
        else run_measurement($urandom_range(0, long_echo ? 40 : edge_wait + 3),
                             $urandom_range(0, echo_lim + 4), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_steady_stream();
    load_timing(20'd1, 8'd1, 8'd1, 8'd0, 20'd30, 16'd40);
    no_idling = 1'b1;
    repeat (6) run_measurement($urandom_range(0, 5), $urandom_range(0, 44), 1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_led();
    test_zero_durations();
    test_busy_commands();
    test_edge_timeout();
    test_no_obstacle();
    test_extremes();
    test_random_ranging();
    test_steady_stream();
    wait_drained();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
